// ----- sv/opd_pkg.sv -----
// ============================================================================
// OpenPGP packet deframer - shared definitions
// Types, codes and constants used by the deframer modules and channels.
// ============================================================================
package opd_pkg;

  // Default width of the body length counter
  localparam int LENGTH_WIDTH_DEF = 32;

  // Reset value of the partial body exponent limit
  localparam logic [4:0] PART_LIMIT_RST = 5'd20;

  // New-format length octet ranges
  localparam logic [7:0] NEWLEN_TWO_FIRST  = 8'd192;
  localparam logic [7:0] NEWLEN_TWO_LAST   = 8'd223;
  localparam logic [7:0] NEWLEN_PART_LAST  = 8'd254;
  localparam logic [15:0] TWO_OCTET_OFFSET = 16'd192;

  // Old-format length types
  localparam logic [1:0] OLD_LT_ONE   = 2'd0;
  localparam logic [1:0] OLD_LT_TWO   = 2'd1;
  localparam logic [1:0] OLD_LT_INDET = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HIGH_BIT  = 3'd1;
  localparam logic [2:0] ERR_TAG_ZERO  = 3'd2;
  localparam logic [2:0] ERR_TAG_UNDEF = 3'd3;
  localparam logic [2:0] ERR_PARTIAL   = 3'd4;
  localparam logic [2:0] ERR_TRUNC     = 3'd5;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NEWLEN = 3'd1,
    PH_BIGLEN = 3'd2,
    PH_TWOLEN = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [5:0] packet_tag;
    logic       new_format;
    logic       end_of_packet;
    logic [2:0] error_code;
  } res_item_t;

  // Configuration write transaction
  typedef struct packed {
    logic [4:0] partial_exponent_limit;
  } cfg_item_t;

  // Defined tags: 1..14, 17..19, 60..63
  function automatic logic tag_defined(input logic [5:0] t);
    return ((t >= 6'd1) && (t <= 6'd14)) ||
           ((t >= 6'd17) && (t <= 6'd19)) ||
           (t >= 6'd60);
  endfunction

endpackage

// ----- sv/opd_chan_if.sv -----
// ============================================================================
// Deframer channel
// Valid/ready channel carrying one payload struct per transaction.
// ============================================================================
interface opd_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/openpgp_packet_deframer_core.sv -----
// ============================================================================
// OpenPGP packet deframer
// Splits a byte stream into packets, decodes headers and lengths, and emits
// body octets tagged with packet tag and format, plus error results.
// ============================================================================
//
//  Channel   Dir  Payload                                   Transaction
//  in_chan   in   data_byte, end_of_data                    one stream octet
//  out_chan  out  payload_byte/valid, tag, format, eop, err  zero or one per octet
//  cfg_chan  in   partial_exponent_limit                    register write
//
//  One octet per cycle sustained while out_chan is ready; a result is on out_chan
//  once its octet has passed the input register and then the result register, with the decode in
//  between. Header and length octets usually produce no result.
//  rst_n is synchronous: clears the channel valids, the parser state and sets
//  the partial exponent limit to 20. No clearing pass.
//  Stalls on out_chan back up through the result register into in_chan ready.
//  cfg_chan is always ready.
//
module openpgp_packet_deframer_core #(
  parameter int LENGTH_WIDTH = opd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  opd_chan_if.sink    in_chan,
  opd_chan_if.source  out_chan,
  opd_chan_if.sink    cfg_chan
);

  logic [4:0]         limit_r, limit_nxt;
  logic               item_valid;
  opd_pkg::in_item_t  item;
  logic               res_ready;
  logic               res_valid;
  opd_pkg::res_item_t res;
  opd_pkg::res_item_t out_data;

  // Configuration register
  assign cfg_chan.ready = 1'b1;
  assign limit_nxt = cfg_chan.valid ? cfg_chan.payload.partial_exponent_limit : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= opd_pkg::PART_LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Input register
  opd_pipe_reg #(
    .T (opd_pkg::in_item_t)
  ) u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_chan.payload),
    .out_valid (item_valid),
    .out_ready (res_ready),
    .out_data  (item)
  );

  // Header, length and body decode
  opd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .part_limit (limit_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  opd_pipe_reg #(
    .T (opd_pkg::res_item_t)
  ) u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.payload = out_data;

endmodule

// ----- sv/opd_pipe_reg.sv -----
// ============================================================================
// Pipeline register slice
// One-entry valid/ready register; accepts when empty or being drained.
// ============================================================================
module opd_pipe_reg #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  T     in_data,
  output logic out_valid,
  input  logic out_ready,
  output T     out_data
);

  logic valid_r, valid_nxt;
  T     data_r;
  logic load;

  // Handshake
  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/opd_parser.sv -----
// ============================================================================
// Packet header parser
// Header/length decode state and the per-octet result logic.
// ============================================================================
module opd_parser #(
  parameter int LENGTH_WIDTH = opd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  opd_pkg::in_item_t   item,
  input  logic                res_ready,
  input  logic [4:0]          part_limit,
  output logic                res_valid,
  output opd_pkg::res_item_t  res
);

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);

  // State
  opd_pkg::phase_t          phase_r, phase_nxt;
  logic [5:0]               tag_r, tag_nxt;
  logic                     fmt_r, fmt_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [2:0]               left_r, left_nxt;
  logic [LENGTH_WIDTH-1:0]  rem_r, rem_nxt;
  logic                     partial_r, partial_nxt;
  logic                     rte_r, rte_nxt;

  logic fire;
  logic emit;
  logic clr;
  logic take_final;

  // Decode of the current octet
  logic [7:0]               b;
  logic                     eod;
  logic [5:0]               hdr_tag;
  logic [1:0]               lt;
  logic                     hdr_ok;
  logic                     nl_one, nl_two, nl_part;
  logic [4:0]               part_exp;
  logic                     part_bad;
  logic [LENGTH_WIDTH-1:0]  part_len;
  logic [15:0]              two_len;
  logic [31:0]              acc_shift;
  logic [2:0]               left_dec;
  logic [31:0]              flen_raw;
  logic [LENGTH_WIDTH-1:0]  flen;
  logic                     flen_zero;
  logic [LENGTH_WIDTH-1:0]  rem_dec;
  logic                     body_last;

  // Clamp a length to the counter width
  function automatic logic [LENGTH_WIDTH-1:0] len_sat(input logic [31:0] v);
    logic [31:0] hi;
    hi = v >> LENGTH_WIDTH;
    if (hi != 32'd0) begin
      return LEN_MAX;
    end
    return v[LENGTH_WIDTH-1:0];
  endfunction

  assign fire = item_valid && res_ready;
  assign b    = item.data_byte;
  assign eod  = item.end_of_data;

  // Header decode
  assign hdr_tag = b[6] ? b[5:0] : {2'b00, b[5:2]};
  assign lt      = b[1:0];
  assign hdr_ok  = b[7] && (hdr_tag != 6'd0) && opd_pkg::tag_defined(hdr_tag);

  // New-format length octet classes
  assign nl_one  = b < opd_pkg::NEWLEN_TWO_FIRST;
  assign nl_two  = !nl_one && (b <= opd_pkg::NEWLEN_TWO_LAST);
  assign nl_part = !nl_one && !nl_two && (b <= opd_pkg::NEWLEN_PART_LAST);

  assign part_exp = b[4:0];
  assign part_bad = part_exp > part_limit;
  assign part_len = (32'(part_exp) >= LENGTH_WIDTH) ? LEN_MAX : (LEN_ONE << part_exp);

  // Final length candidates
  assign two_len   = {2'b00, acc_r[5:0], 8'h00} + 16'(b) + opd_pkg::TWO_OCTET_OFFSET;
  assign acc_shift = {acc_r[23:0], b};
  assign left_dec  = left_r - 3'd1;

  always_comb begin
    unique case (phase_r)
      opd_pkg::PH_NEWLEN: flen_raw = 32'(b);
      opd_pkg::PH_TWOLEN: flen_raw = 32'(two_len);
      default:            flen_raw = acc_shift;
    endcase
  end

  assign flen      = len_sat(flen_raw);
  assign flen_zero = (flen_raw == 32'd0);

  // Body countdown
  assign rem_dec   = (rem_r != '0) ? (rem_r - LEN_ONE) : rem_r;
  assign body_last = (rem_dec == '0);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      opd_pkg::PH_HEADER: begin
        if (!hdr_ok || eod) begin
          phase_nxt = opd_pkg::PH_HEADER;
        end else if (b[6]) begin
          phase_nxt = opd_pkg::PH_NEWLEN;
        end else if (lt == opd_pkg::OLD_LT_INDET) begin
          phase_nxt = opd_pkg::PH_BODY;
        end else begin
          phase_nxt = opd_pkg::PH_BIGLEN;
        end
      end
      opd_pkg::PH_NEWLEN: begin
        priority if (nl_one) begin
          phase_nxt = (flen_zero || eod) ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
        end else if (nl_two) begin
          phase_nxt = eod ? opd_pkg::PH_HEADER : opd_pkg::PH_TWOLEN;
        end else if (nl_part) begin
          phase_nxt = (part_bad || eod) ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
        end else begin
          phase_nxt = eod ? opd_pkg::PH_HEADER : opd_pkg::PH_BIGLEN;
        end
      end
      opd_pkg::PH_TWOLEN: begin
        phase_nxt = (flen_zero || eod) ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
      end
      opd_pkg::PH_BIGLEN: begin
        if (left_dec == 3'd0) begin
          phase_nxt = (flen_zero || eod) ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
        end else begin
          phase_nxt = eod ? opd_pkg::PH_HEADER : opd_pkg::PH_BIGLEN;
        end
      end
      opd_pkg::PH_BODY: begin
        if (rte_r) begin
          phase_nxt = eod ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
        end else if (body_last) begin
          phase_nxt = (!partial_r || eod) ? opd_pkg::PH_HEADER : opd_pkg::PH_NEWLEN;
        end else begin
          phase_nxt = eod ? opd_pkg::PH_HEADER : opd_pkg::PH_BODY;
        end
      end
      default: phase_nxt = opd_pkg::PH_HEADER;
    endcase
  end

  // Result and length datapath
  always_comb begin
    tag_nxt     = tag_r;
    fmt_nxt     = fmt_r;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    rem_nxt     = rem_r;
    partial_nxt = partial_r;
    rte_nxt     = rte_r;
    emit        = 1'b0;
    clr         = 1'b0;
    take_final  = 1'b0;

    res.payload_byte  = 8'h00;
    res.payload_valid = 1'b0;
    res.packet_tag    = tag_r;
    res.new_format    = fmt_r;
    res.end_of_packet = 1'b0;
    res.error_code    = opd_pkg::ERR_NONE;

    unique case (phase_r)
      opd_pkg::PH_HEADER: begin
        if (!b[7]) begin
          // not a header octet: report and stay in header phase
          emit              = 1'b1;
          res.packet_tag    = 6'd0;
          res.new_format    = 1'b0;
          res.end_of_packet = 1'b1;
          res.error_code    = opd_pkg::ERR_HIGH_BIT;
        end else begin
          tag_nxt        = hdr_tag;
          fmt_nxt        = b[6];
          res.packet_tag = hdr_tag;
          res.new_format = b[6];
          if (hdr_tag == 6'd0) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TAG_ZERO;
            clr               = 1'b1;
          end else if (!opd_pkg::tag_defined(hdr_tag)) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TAG_UNDEF;
            clr               = 1'b1;
          end else begin
            partial_nxt = 1'b0;
            rte_nxt     = 1'b0;
            acc_nxt     = 32'd0;
            rem_nxt     = '0;
            if (b[6]) begin
              if (eod) begin
                emit              = 1'b1;
                res.end_of_packet = 1'b1;
                res.error_code    = opd_pkg::ERR_TRUNC;
                clr               = 1'b1;
              end
            end else if (lt == opd_pkg::OLD_LT_INDET) begin
              if (eod) begin
                // empty indeterminate packet
                emit              = 1'b1;
                res.end_of_packet = 1'b1;
                clr               = 1'b1;
              end else begin
                rte_nxt = 1'b1;
              end
            end else begin
              priority if (lt == opd_pkg::OLD_LT_ONE) begin
                left_nxt = 3'd1;
              end else if (lt == opd_pkg::OLD_LT_TWO) begin
                left_nxt = 3'd2;
              end else begin
                left_nxt = 3'd4;
              end
              if (eod) begin
                emit              = 1'b1;
                res.end_of_packet = 1'b1;
                res.error_code    = opd_pkg::ERR_TRUNC;
                clr               = 1'b1;
              end
            end
          end
        end
      end
      opd_pkg::PH_NEWLEN: begin
        priority if (nl_one) begin
          take_final = 1'b1;
        end else if (nl_two) begin
          acc_nxt = {24'd0, b - opd_pkg::NEWLEN_TWO_FIRST};
          if (eod) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TRUNC;
            clr               = 1'b1;
          end
        end else if (nl_part) begin
          if (part_bad) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_PARTIAL;
            clr               = 1'b1;
          end else if (eod) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TRUNC;
            clr               = 1'b1;
          end else begin
            partial_nxt = 1'b1;
            rem_nxt     = part_len;
          end
        end else begin
          // five-octet length
          acc_nxt  = 32'd0;
          left_nxt = 3'd4;
          if (eod) begin
            emit              = 1'b1;
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TRUNC;
            clr               = 1'b1;
          end
        end
      end
      opd_pkg::PH_TWOLEN: begin
        take_final = 1'b1;
      end
      opd_pkg::PH_BIGLEN: begin
        acc_nxt  = acc_shift;
        left_nxt = left_dec;
        if (left_dec == 3'd0) begin
          take_final = 1'b1;
        end else if (eod) begin
          emit              = 1'b1;
          res.end_of_packet = 1'b1;
          res.error_code    = opd_pkg::ERR_TRUNC;
          clr               = 1'b1;
        end
      end
      opd_pkg::PH_BODY: begin
        emit              = 1'b1;
        res.payload_byte  = b;
        res.payload_valid = 1'b1;
        if (rte_r) begin
          if (eod) begin
            res.end_of_packet = 1'b1;
            clr               = 1'b1;
          end
        end else begin
          rem_nxt = rem_dec;
          if (body_last && !partial_r) begin
            res.end_of_packet = 1'b1;
            clr               = 1'b1;
          end else if (eod) begin
            res.end_of_packet = 1'b1;
            res.error_code    = opd_pkg::ERR_TRUNC;
            clr               = 1'b1;
          end
        end
      end
      default: begin
        clr = 1'b1;
      end
    endcase

    // Final body length known
    if (take_final) begin
      partial_nxt = 1'b0;
      rem_nxt     = flen;
      if (flen_zero) begin
        emit              = 1'b1;
        res.end_of_packet = 1'b1;
        clr               = 1'b1;
      end else if (eod) begin
        emit              = 1'b1;
        res.end_of_packet = 1'b1;
        res.error_code    = opd_pkg::ERR_TRUNC;
        clr               = 1'b1;
      end
    end

    // Packet end clears the length state
    if (clr) begin
      partial_nxt = 1'b0;
      rte_nxt     = 1'b0;
      rem_nxt     = '0;
      acc_nxt     = 32'd0;
      left_nxt    = 3'd0;
    end
  end

  assign res_valid = item_valid && emit;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= opd_pkg::PH_HEADER;
      tag_r     <= 6'd0;
      fmt_r     <= 1'b0;
      acc_r     <= 32'd0;
      left_r    <= 3'd0;
      rem_r     <= '0;
      partial_r <= 1'b0;
      rte_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      tag_r     <= tag_nxt;
      fmt_r     <= fmt_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      rem_r     <= rem_nxt;
      partial_r <= partial_nxt;
      rte_r     <= rte_nxt;
    end
  end

  // Checks
  a_err_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.error_code != opd_pkg::ERR_NONE)) |-> res.end_of_packet)
    else $error("error result without end of packet");

  a_eop_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && res.end_of_packet) |=> (phase_r == opd_pkg::PH_HEADER))
    else $error("packet end did not return to header phase");

  a_counted_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == opd_pkg::PH_BODY) && !rte_r) |-> (rem_r != '0))
    else $error("counted body with zero bytes left");

  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rte_r && partial_r))
    else $error("indeterminate and partial body at once");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.payload_valid) |-> (res.payload_byte == 8'h00))
    else $error("nonzero byte on result without payload");

endmodule

// ----- tb/opd_deframer_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// OpenPGP packet deframer - result checker
// Watches the octet, result and limit-write channels. Every accepted octet is
// run through a cycle-free deframer of its own; any result it yields is queued
// and compared field by field with the next result the block hands out.
// ============================================================================
module opd_deframer_checker
  import opd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  res_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_item,
  output int        mismatch_count,
  output int        results_pending
);

  // Deframer state as seen from the stream
  phase_t      ph;
  logic [5:0]  cur_tag;
  logic        cur_fmt;
  logic [31:0] len_acc;
  logic [2:0]  octets_left;
  logic [31:0] body_left;
  logic        partial_chunk;
  logic        to_end;
  logic [4:0]  exp_limit;

  res_item_t   expected_results[$];

  function automatic bit known_tag(input logic [5:0] t);
    return t inside {[6'd1:6'd14], [6'd17:6'd19], [6'd60:6'd63]};
  endfunction

  // Ends the current packet with one result; next octet is a header
  function automatic bit close_packet(input logic [7:0] b, input logic bv,
                                      input logic [2:0] err, output res_item_t r);
    r.payload_byte  = bv ? b : 8'd0;
    r.payload_valid = bv;
    r.packet_tag    = cur_tag;
    r.new_format    = cur_fmt;
    r.end_of_packet = 1'b1;
    r.error_code    = err;
    ph            = PH_HEADER;
    partial_chunk = 1'b0;
    to_end        = 1'b0;
    body_left     = '0;
    len_acc       = '0;
    octets_left   = '0;
    return 1'b1;
  endfunction

  // Body octet in the middle of a packet
  function automatic bit body_octet(input logic [7:0] b, output res_item_t r);
    r.payload_byte  = b;
    r.payload_valid = 1'b1;
    r.packet_tag    = cur_tag;
    r.new_format    = cur_fmt;
    r.end_of_packet = 1'b0;
    r.error_code    = ERR_NONE;
    return 1'b1;
  endfunction

  // Final (non-partial) body length is known
  function automatic bit take_length(input logic [63:0] len, input logic eod,
                                     output res_item_t r);
    partial_chunk = 1'b0;
    body_left = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
    if (body_left == 0) return close_packet(8'd0, 1'b0, ERR_NONE, r);
    if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
    ph = PH_BODY;
    return 1'b0;
  endfunction

  // One stream octet in, zero or one result out
  function automatic bit deframe_octet(input in_item_t it, output res_item_t r);
    logic [7:0] b;
    logic       eod;
    logic [4:0] ex;
    b   = it.data_byte;
    eod = it.end_of_data;
    r   = '0;
    case (ph)
      PH_HEADER: begin
        if (!b[7]) begin
          r.end_of_packet = 1'b1;
          r.error_code    = ERR_HIGH_BIT;
          return 1'b1;
        end
        cur_fmt = b[6];
        cur_tag = b[6] ? b[5:0] : {2'b00, b[5:2]};
        if (cur_tag == 6'd0) return close_packet(8'd0, 1'b0, ERR_TAG_ZERO, r);
        if (!known_tag(cur_tag)) return close_packet(8'd0, 1'b0, ERR_TAG_UNDEF, r);
        partial_chunk = 1'b0;
        to_end        = 1'b0;
        len_acc       = '0;
        body_left     = '0;
        if (cur_fmt) begin
          if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
          ph = PH_NEWLEN;
          return 1'b0;
        end
        if (b[1:0] == OLD_LT_INDET) begin
          if (eod) return close_packet(8'd0, 1'b0, ERR_NONE, r);
          to_end = 1'b1;
          ph     = PH_BODY;
          return 1'b0;
        end
        octets_left = (b[1:0] == OLD_LT_ONE) ? 3'd1 : (b[1:0] == OLD_LT_TWO) ? 3'd2 : 3'd4;
        if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
        ph = PH_BIGLEN;
        return 1'b0;
      end
      PH_NEWLEN: begin
        if (b < NEWLEN_TWO_FIRST) return take_length(64'(b), eod, r);
        if (b <= NEWLEN_TWO_LAST) begin
          len_acc = 32'(b - NEWLEN_TWO_FIRST);
          if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
          ph = PH_TWOLEN;
          return 1'b0;
        end
        if (b <= NEWLEN_PART_LAST) begin
          ex = b[4:0];
          if (ex > exp_limit) return close_packet(8'd0, 1'b0, ERR_PARTIAL, r);
          if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
          partial_chunk = 1'b1;
          body_left     = 32'd1 << ex;
          ph            = PH_BODY;
          return 1'b0;
        end
        // five-octet length follows
        len_acc     = '0;
        octets_left = 3'd4;
        if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
        ph = PH_BIGLEN;
        return 1'b0;
      end
      PH_TWOLEN:
        return take_length((64'(len_acc) << 8) + 64'(b) + 64'(TWO_OCTET_OFFSET), eod, r);
      PH_BIGLEN: begin
        len_acc     = {len_acc[23:0], b};
        octets_left = octets_left - 3'd1;
        if (octets_left == 3'd0) return take_length(64'(len_acc), eod, r);
        if (eod) return close_packet(8'd0, 1'b0, ERR_TRUNC, r);
        return 1'b0;
      end
      default: begin
        // body octet
        if (to_end) begin
          if (eod) return close_packet(b, 1'b1, ERR_NONE, r);
          return body_octet(b, r);
        end
        if (body_left != 0) body_left = body_left - 32'd1;
        if (body_left == 0) begin
          if (!partial_chunk) return close_packet(b, 1'b1, ERR_NONE, r);
          if (eod) return close_packet(b, 1'b1, ERR_TRUNC, r);
          ph = PH_NEWLEN;
          return body_octet(b, r);
        end
        if (eod) return close_packet(b, 1'b1, ERR_TRUNC, r);
        return body_octet(b, r);
      end
    endcase
  endfunction

  function automatic bit fields_match(input res_item_t a, input res_item_t b);
    return (a.payload_byte === b.payload_byte) && (a.payload_valid === b.payload_valid) &&
           (a.packet_tag === b.packet_tag) && (a.new_format === b.new_format) &&
           (a.end_of_packet === b.end_of_packet) && (a.error_code === b.error_code);
  endfunction

  // Count every bad result, show only the first few
  task automatic note_mismatch(input bit unexpected, input res_item_t want,
                               input res_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (unexpected)
        $display("%0t: unexpected result byte=%02h pv=%0b tag=%0d new=%0b eop=%0b err=%0d",
                 $time, got.payload_byte, got.payload_valid, got.packet_tag,
                 got.new_format, got.end_of_packet, got.error_code);
      else
        $display("%0t: result mismatch exp byte=%02h pv=%0b tag=%0d new=%0b eop=%0b err=%0d",
                 $time, want.payload_byte, want.payload_valid, want.packet_tag,
                 want.new_format, want.end_of_packet, want.error_code,
                 " / got byte=%02h pv=%0b tag=%0d new=%0b eop=%0b err=%0d",
                 got.payload_byte, got.payload_valid, got.packet_tag,
                 got.new_format, got.end_of_packet, got.error_code);
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin : watch
    res_item_t want;
    res_item_t pred;
    if (!rst_n) begin
      ph             = PH_HEADER;
      cur_tag        = '0;
      cur_fmt        = 1'b0;
      len_acc        = '0;
      octets_left    = '0;
      body_left      = '0;
      partial_chunk  = 1'b0;
      to_end         = 1'b0;
      exp_limit      = PART_LIMIT_RST;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      // results first: nothing accepted this edge can already be out
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch(1'b1, '0, out_item);
        end else begin
          want = expected_results.pop_front();
          if (!fields_match(want, out_item)) note_mismatch(1'b0, want, out_item);
        end
      end
      if (cfg_valid && cfg_ready) exp_limit = cfg_item.partial_exponent_limit;
      if (in_valid && in_ready) begin
        if (deframe_octet(in_item, pred)) expected_results.push_back(pred);
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// ----- tb/tb_openpgp_packet_deframer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// OpenPGP packet deframer - testbench top
// Feeds a directed opening stream and then random packet streams (old and new
// headers, every length form, partial chains, noise, cut-off packets) under
// several exponent limits and random stalls on both channels; the checker
// beside the block decides every result.
// ============================================================================
module tb_openpgp_packet_deframer_core;
  import opd_pkg::*;

  localparam int         RANDOM_ITEMS      = 1750;
  localparam int         PHASES            = 5;
  localparam logic [1:0] OLD_LT_FOUR       = 2'd2;
  localparam logic [7:0] NEWLEN_PART_FIRST = 8'd224;
  localparam logic [7:0] NEWLEN_FIVE       = 8'd255;

  logic clk = 1'b0;
  logic rst_n;

  opd_chan_if #(.T(in_item_t))  in_if ();
  opd_chan_if #(.T(res_item_t)) out_if ();
  opd_chan_if #(.T(cfg_item_t)) cfg_if ();

  int mismatches;
  int pending;
  int sent_items = 0;
  int tx_max_gap = 10;
  int rx_max_gap = 10;
  int hold_requests = 0;

  logic [7:0] pkt_q[$];

  openpgp_packet_deframer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  opd_deframer_checker deframe_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_item         (in_if.payload),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_item        (out_if.payload),
    .cfg_valid       (cfg_if.valid),
    .cfg_ready       (cfg_if.ready),
    .cfg_item        (cfg_if.payload),
    .mismatch_count  (mismatches),
    .results_pending (pending)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("openpgp_packet_deframer_core verification failed");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int gap;
    int holds_served;
    holds_served = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = (rx_max_gap > 0) ? $urandom_range(0, rx_max_gap) : 0;
      if (hold_requests > holds_served) begin
        holds_served++;
        gap = 300;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // One octet transaction; entered and left at a falling edge
  task automatic push_octet(input logic [7:0] b, input logic eod);
    int gap;
    gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.payload <= '{data_byte: b, end_of_data: eod};
    in_if.valid   <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sent_items++;
    @(negedge clk);
  endtask

  // Stop offering and let the block run dry
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    wait_for_drain();
    cfg_if.payload <= cfg_item_t'(v);
    cfg_if.valid   <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Send the queued packet; optionally cut it short with end of data
  task automatic push_queue(input bit cut, input bit end_stream);
    int k;
    int i;
    k = cut ? $urandom_range(0, pkt_q.size() - 1) : pkt_q.size() - 1;
    for (i = 0; i <= k; i++) push_octet(pkt_q[i], (i == k) && (cut || end_stream));
  endtask

  // Mostly defined tags, now and then zero or undefined
  function automatic logic [5:0] pick_tag(input bit newf);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return newf ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
    if (!newf || r < 70) return 6'($urandom_range(1, 14));
    if (r < 85) return 6'($urandom_range(17, 19));
    return 6'($urandom_range(60, 63));
  endfunction

  function automatic int small_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(13, 191) : $urandom_range(0, 12);
  endfunction

  task automatic add_body(input int n);
    repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_word(input logic [31:0] w);
    pkt_q.push_back(w[31:24]);
    pkt_q.push_back(w[23:16]);
    pkt_q.push_back(w[15:8]);
    pkt_q.push_back(w[7:0]);
  endtask

  // Well-formed packet with random content; open_end set for indeterminate
  task automatic build_packet(output bit open_end);
    bit         newf;
    logic [5:0] tag;
    logic [1:0] lt;
    int         len;
    int         form;
    int         e;
    pkt_q.delete();
    open_end = 1'b0;
    newf = ($urandom_range(0, 99) < 55);
    tag  = pick_tag(newf);
    len  = small_len();
    if (!newf) begin
      lt = 2'($urandom_range(0, 3));
      pkt_q.push_back({2'b10, tag[3:0], lt});
      case (lt)
        OLD_LT_ONE: pkt_q.push_back(8'(len));
        OLD_LT_TWO: begin
          pkt_q.push_back(8'(len >> 8));
          pkt_q.push_back(8'(len));
        end
        OLD_LT_FOUR: add_word(32'(len));
        default: open_end = 1'b1;
      endcase
      add_body(len);
    end else begin
      pkt_q.push_back({2'b11, tag});
      // partial chunks ahead of the final length
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          e = $urandom_range(0, 5);
          pkt_q.push_back(NEWLEN_PART_FIRST + 8'(e));
          add_body(1 << e);
        end
      end
      form = $urandom_range(0, 31);
      if (form <= 20) begin
        pkt_q.push_back(8'(len));
      end else if (form == 21) begin
        len = $urandom_range(192, 260);
        pkt_q.push_back(NEWLEN_TWO_FIRST + 8'((len - 192) >> 8));
        pkt_q.push_back(8'(len - 192));
      end else begin
        pkt_q.push_back(NEWLEN_FIVE);
        add_word(32'(len));
      end
      add_body(len);
    end
  endtask

  // Packet announcing far more body than it carries
  task automatic build_oversized();
    logic [31:0] big;
    logic [5:0]  old_tag;
    pkt_q.delete();
    big = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0001_0000);
    case ($urandom_range(0, 3))
      0: begin
        pkt_q.push_back({2'b11, pick_tag(1'b1)});
        pkt_q.push_back(8'($urandom_range(NEWLEN_TWO_FIRST, NEWLEN_TWO_LAST)));
        pkt_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        pkt_q.push_back({2'b11, pick_tag(1'b1)});
        pkt_q.push_back(NEWLEN_FIVE);
        add_word(big);
      end
      2: begin
        old_tag = pick_tag(1'b0);
        pkt_q.push_back({2'b10, old_tag[3:0], OLD_LT_FOUR});
        add_word(big);
      end
      default: begin
        pkt_q.push_back({2'b11, pick_tag(1'b1)});
        pkt_q.push_back(8'($urandom_range(NEWLEN_PART_FIRST + 8, NEWLEN_PART_LAST)));
      end
    endcase
    add_body($urandom_range(1, 4));
  endtask

  task automatic random_packet();
    int r;
    bit open_end;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // noise
      pkt_q.delete();
      add_body($urandom_range(1, 3));
      push_queue(1'b0, $urandom_range(0, 7) == 0);
    end else if (r < 12) begin
      build_oversized();
      push_queue(1'b0, 1'b1);
    end else begin
      build_packet(open_end);
      if (r < 20) push_queue(1'b1, 1'b0);
      else push_queue(1'b0, open_end || ($urandom_range(0, 9) == 0));
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int         phase_idx;
    int         target;
    bit         mid_done;
    bit         open_end;
    logic [4:0] limits [PHASES];
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, limit at its reset value
    push_octet(8'h00, 1'b0);                            // high bit clear
    push_octet(8'h80, 1'b0);                            // old header, tag zero
    push_octet(8'hCF, 1'b0);                            // new header, undefined tag
    push_octet(8'hFF, 1'b0); push_octet(8'h00, 1'b0);   // tag 63, empty body
    push_octet(8'h88, 1'b0); push_octet(8'h01, 1'b0);   // old one-octet length
    push_octet(8'hFF, 1'b0);
    push_octet(8'h8A, 1'b0);                            // old four-octet, empty
    push_octet(8'h00, 1'b0); push_octet(8'h00, 1'b0);
    push_octet(8'h00, 1'b0); push_octet(8'h00, 1'b0);
    push_octet(8'hCB, 1'b0); push_octet(8'hE0, 1'b0);   // partial chunk of one
    push_octet(8'h11, 1'b0); push_octet(8'h01, 1'b0);   // then final one-octet
    push_octet(8'h22, 1'b0);
    push_octet(8'hCB, 1'b0); push_octet(8'hF5, 1'b0);   // exponent 21 over limit
    push_octet(8'hAF, 1'b0); push_octet(8'h33, 1'b0);   // indeterminate length
    push_octet(8'h44, 1'b1);
    push_octet(8'hC2, 1'b0); push_octet(8'hC0, 1'b1);   // data ends in a length

    limits = '{PART_LIMIT_RST, 5'd0, 5'd30, 5'($urandom_range(1, 29)),
               5'($urandom_range(0, 30))};
    for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      case (phase_idx)
        1: begin tx_max_gap = 0;  rx_max_gap = 0;  end
        2: begin tx_max_gap = 0;  rx_max_gap = 10; end
        3: begin tx_max_gap = 10; rx_max_gap = 0;  end
        default: begin tx_max_gap = 10; rx_max_gap = 10; end
      endcase
      if (phase_idx != 0) write_limit(limits[phase_idx]);
      target   = sent_items + RANDOM_ITEMS / PHASES;
      mid_done = 1'b0;
      while (sent_items < target) begin
        if (!mid_done && sent_items >= target - RANDOM_ITEMS / (2 * PHASES)) begin
          mid_done = 1'b1;
          // long result stall while octets keep coming, or a full drain
          if (phase_idx == 2) hold_requests++;
          if (phase_idx == 3) wait_for_drain();
        end
        random_packet();
      end
      // close the stream so the parser is back at a header
      build_packet(open_end);
      push_queue(1'b0, 1'b1);
    end

    wait_for_drain();
    if (mismatches == 0 && pending == 0)
      $display("openpgp_packet_deframer_core verification clean");
    else
      $display("openpgp_packet_deframer_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/opd_pkg.sv
sv/opd_chan_if.sv
sv/opd_pipe_reg.sv
sv/opd_parser.sv
sv/openpgp_packet_deframer_core.sv
tb/opd_deframer_checker.sv
tb/tb_openpgp_packet_deframer_core.sv
